/* sv/tmpf_pkg.sv */
// shared types and constants of the tile map pixel fetch block
`timescale 1ns / 1ps
package tmpf_pkg;

    localparam int BANK_BYTES  = 8192;
    localparam int ADDR_W      = 13;
    localparam int VRAM_IDX_W  = ADDR_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_ADDR_W  = 3;

    // command codes carried in tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TILE_DATA_SEL = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BG_ENABLE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIN_ENABLE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLOR_MODE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BG_MAP_SEL    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIN_MAP_SEL   = 3'd5;

    // maps sit at 0x1800 / 0x1c00, both with the top two address bits set
    localparam logic [1:0]        MAP_BASE_HI      = 2'b11;
    localparam logic [ADDR_W-1:0] SIGNED_TILE_BASE = 13'h0800;
    localparam logic [7:0]        SIGNED_TILE_BIAS = 8'h80;
    localparam logic [7:0]        WIN_X_OFFSET     = 8'd7;

    // attribute byte layout
    localparam int ATTR_BANK_BIT  = 3;
    localparam int ATTR_XFLIP_BIT = 5;
    localparam int ATTR_YFLIP_BIT = 6;
    localparam int ATTR_PRIO_BIT  = 7;

    typedef struct packed {
        logic tile_data_select;
        logic background_enable;
        logic window_enable;
        logic color_mode;
        logic background_map_select;
        logic window_map_select;
    } cfg_t;

    // one queued job: a byte write or a classified pixel
    typedef struct packed {
        logic              is_pixel;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wbyte;
        logic [7:0]        column;
        logic [2:0]        fine_x;
        logic [2:0]        fine_y;
        logic              drawn;
        logic              from_window;
    } entry_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic busy;
        logic emit;
    } bk_status_t;

    typedef struct packed {
        logic [7:0] column;
        logic [1:0] color;
        logic [2:0] palette;
        logic       prio;
        logic       from_window;
        logic       drawn;
    } result_t;

endpackage

/* sv/tmpf_front.sv */
// front end: unpacks input transfers and picks layer and map address per pixel
`timescale 1ns / 1ps
module tmpf_front #(
    parameter int SCREEN_WIDTH = 160
) (
    input  tmpf_pkg::cfg_t                    cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tmpf_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                        s_tuser,
    input  tmpf_pkg::q_status_t               q_st,
    output logic                              push,
    output tmpf_pkg::entry_t                  push_entry
);
    import tmpf_pkg::*;

    logic              bank;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        wbyte;
    logic [7:0]        x;
    logic [7:0]        ly;
    logic [7:0]        scx;
    logic [7:0]        scy;
    logic [7:0]        wx;
    logic [7:0]        wy;
    logic              on_screen;
    logic [8:0]        x_plus;
    logic              win_hit;
    logic              use_win;
    logic              use_bg;
    logic [7:0]        mx;
    logic [7:0]        my;
    logic              map_sel;
    logic [ADDR_W-1:0] map_addr;

    assign bank     = s_tdata[0];
    assign mem_addr = s_tdata[13:1];
    assign wbyte    = s_tdata[21:14];
    assign x        = s_tdata[29:22];
    assign ly       = s_tdata[37:30];
    assign scx      = s_tdata[45:38];
    assign scy      = s_tdata[53:46];
    assign wx       = s_tdata[61:54];
    assign wy       = s_tdata[69:62];

    assign on_screen = {1'b0, x} < 9'(SCREEN_WIDTH);
    assign x_plus    = {1'b0, x} + {1'b0, WIN_X_OFFSET};
    assign win_hit   = cfg.window_enable && (wy <= ly) && (x_plus >= {1'b0, wx});
    assign use_win   = on_screen && win_hit;
    assign use_bg    = on_screen && !win_hit && (cfg.background_enable || cfg.color_mode);

    // map coordinates wrap at 256
    always_comb begin
        if (use_win) begin
            mx      = 8'(x + WIN_X_OFFSET - wx);
            my      = 8'(ly - wy);
            map_sel = cfg.window_map_select;
        end else begin
            mx      = 8'(scx + x);
            my      = 8'(scy + ly);
            map_sel = cfg.background_map_select;
        end
    end

    assign map_addr = {MAP_BASE_HI, map_sel, my[7:3], mx[7:3]};

    assign s_tready = !q_st.full;
    assign push     = s_tvalid && !q_st.full;

    always_comb begin
        push_entry.is_pixel    = (s_tuser[0] == CMD_PIXEL);
        push_entry.bank        = bank;
        push_entry.addr        = (s_tuser[0] == CMD_PIXEL) ? map_addr : mem_addr;
        push_entry.wbyte       = wbyte;
        push_entry.column      = x;
        push_entry.fine_x      = mx[2:0];
        push_entry.fine_y      = my[2:0];
        push_entry.drawn       = use_win || use_bg;
        push_entry.from_window = use_win;
    end

endmodule

/* sv/tmpf_queue.sv */
// small job queue between the front end and the fetch sequencer
`timescale 1ns / 1ps
module tmpf_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tmpf_pkg::entry_t    push_entry,
    input  logic                pop,
    output tmpf_pkg::entry_t    head,
    output tmpf_pkg::q_status_t q_st
);
    import tmpf_pkg::*;

    entry_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign do_push = push && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = slots_reg[rd_ptr_reg];
    assign q_st.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_st.empty = (count_reg == '0);
    assign q_st.count = count_reg;

endmodule

/* sv/tmpf_back.sv */
// back end: video memory and the map, attribute and tile plane read sequencer
`timescale 1ns / 1ps
module tmpf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tmpf_pkg::cfg_t       cfg,
    input  tmpf_pkg::entry_t     head,
    input  tmpf_pkg::q_status_t  q_st,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output tmpf_pkg::result_t    result,
    output tmpf_pkg::bk_status_t bk_st
);
    import tmpf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ATTR = 3'd1;
    localparam logic [2:0] ST_LO   = 3'd2;
    localparam logic [2:0] ST_HI   = 3'd3;
    localparam logic [2:0] ST_PIX  = 3'd4;

    logic [7:0]            vram [2 * BANK_BYTES];
    logic [7:0]            rd_data_reg;
    logic [VRAM_IDX_W-1:0] rd_idx;
    logic                  mem_we;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    entry_t      job_reg;
    logic [7:0]  tile_reg;
    logic [7:0]  attr_reg;
    logic [7:0]  lo_reg;
    logic        m_tvalid_reg;
    result_t     result_reg;

    logic [7:0]  attr_now;
    logic [2:0]  fy_lo;
    logic [2:0]  fy_hi;
    logic [2:0]  shift;
    logic        emit;
    result_t     result_next;

    function automatic logic [ADDR_W-1:0] tile_addr(
        input logic       tds,
        input logic [7:0] tile,
        input logic [2:0] fy,
        input logic       plane
    );
        logic [7:0]        idx;
        logic [ADDR_W-1:0] base;
        idx  = tds ? tile : (tile ^ SIGNED_TILE_BIAS);
        base = tds ? '0 : SIGNED_TILE_BASE;
        return ADDR_W'(base + {1'b0, idx, fy, plane});
    endfunction

    // attribute byte only counts in colour mode
    assign attr_now = cfg.color_mode ? rd_data_reg : 8'h00;
    assign fy_lo    = attr_now[ATTR_YFLIP_BIT] ? ~job_reg.fine_y : job_reg.fine_y;
    assign fy_hi    = attr_reg[ATTR_YFLIP_BIT] ? ~job_reg.fine_y : job_reg.fine_y;
    assign shift    = attr_reg[ATTR_XFLIP_BIT] ? job_reg.fine_x : ~job_reg.fine_x;

    assign pop    = (state_reg == ST_IDLE) && !q_st.empty;
    assign mem_we = pop && !head.is_pixel;
    assign emit   = (state_reg == ST_PIX) && (!m_tvalid_reg || m_tready);

    always_comb begin
        unique case (state_reg) inside
            ST_IDLE: rd_idx = {1'b0, head.addr};
            ST_ATTR: rd_idx = {1'b1, job_reg.addr};
            ST_LO: rd_idx = {attr_now[ATTR_BANK_BIT],
                             tile_addr(cfg.tile_data_select, tile_reg, fy_lo, 1'b0)};
            ST_HI, ST_PIX: rd_idx = {attr_reg[ATTR_BANK_BIT],
                                     tile_addr(cfg.tile_data_select, tile_reg, fy_hi, 1'b1)};
            default: rd_idx = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            vram[{head.bank, head.addr}] <= head.wbyte;
        end
        rd_data_reg <= vram[rd_idx];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop && head.is_pixel) begin
                    state_next = head.drawn ? ST_ATTR : ST_PIX;
                end
            end
            ST_ATTR: state_next = ST_LO;
            ST_LO:   state_next = ST_HI;
            ST_HI:   state_next = ST_PIX;
            ST_PIX: begin
                if (emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        result_next.column      = job_reg.column;
        result_next.color       = job_reg.drawn ? {rd_data_reg[shift], lo_reg[shift]} : 2'b00;
        result_next.palette     = job_reg.drawn ? attr_reg[2:0] : 3'b000;
        result_next.prio        = job_reg.drawn && attr_reg[ATTR_PRIO_BIT];
        result_next.from_window = job_reg.from_window;
        result_next.drawn       = job_reg.drawn;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head;
        end
        if (state_reg == ST_ATTR) begin
            tile_reg <= rd_data_reg;
        end
        if (state_reg == ST_LO) begin
            attr_reg <= attr_now;
        end
        if (state_reg == ST_HI) begin
            lo_reg <= rd_data_reg;
        end
        if (emit) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign result     = result_reg;
    assign bk_st.busy = (state_reg != ST_IDLE);
    assign bk_st.emit = emit;

endmodule

/* sv/tile_map_pixel_fetch_core.sv */
// top level of the tile map pixel fetch block
`timescale 1ns / 1ps
// Background and window pixel fetch over two 8 KiB video memory banks. An input
// transfer with tuser 0 writes one byte and gives no result; with tuser 1 it
// fetches one pixel and gives exactly one result, in input order. A write is done
// as it leaves the queue; a drawn pixel steps through map, attribute, low plane
// and high plane reads and the result, an undrawn one straight to the result, as
// all four reads go in turn through the single read port of the video memory
// and the plane addresses use bytes read before. A four-entry job queue lets
// the input side keep accepting while the sequencer works, and a result register
// holds a finished pixel while the sink stalls. Video memory has no reset and
// must be written before it is read. Configuration writes take effect at once
// and are meant to happen while the block is idle; indexes 6 and 7 are ignored.
module tile_map_pixel_fetch_core #(
    parameter int SCREEN_WIDTH = 160
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // bank[0], address[13:1], byte[21:14], column[29:22], line[37:30],
    // scroll_x[45:38], scroll_y[53:46], window_x[61:54], window_y[69:62]
    input  logic [tmpf_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command[0]
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_column[7:0], color_index[9:8], palette_number[12:10],
    // bg_priority[13], drawn[14]
    output logic [tmpf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // from_window[0]
    output logic [0:0]                          m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [tmpf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [0:0]                          cfg_wdata
);
    import tmpf_pkg::*;

    cfg_t       cfg_reg;
    logic       push;
    entry_t     push_entry;
    logic       pop;
    entry_t     head;
    q_status_t  q_st;
    result_t    result;
    bk_status_t bk_st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tile_data_select      <= 1'b1;
            cfg_reg.background_enable     <= 1'b1;
            cfg_reg.window_enable         <= 1'b0;
            cfg_reg.color_mode            <= 1'b0;
            cfg_reg.background_map_select <= 1'b0;
            cfg_reg.window_map_select     <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TILE_DATA_SEL: cfg_reg.tile_data_select      <= cfg_wdata[0];
                CFG_BG_ENABLE:     cfg_reg.background_enable     <= cfg_wdata[0];
                CFG_WIN_ENABLE:    cfg_reg.window_enable         <= cfg_wdata[0];
                CFG_COLOR_MODE:    cfg_reg.color_mode            <= cfg_wdata[0];
                CFG_BG_MAP_SEL:    cfg_reg.background_map_select <= cfg_wdata[0];
                CFG_WIN_MAP_SEL:   cfg_reg.window_map_select     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    tmpf_front #(
        .SCREEN_WIDTH(SCREEN_WIDTH)
    ) u_front (
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_st      (q_st),
        .push      (push),
        .push_entry(push_entry)
    );

    tmpf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .q_st      (q_st)
    );

    tmpf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .head    (head),
        .q_st    (q_st),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .result  (result),
        .bk_st   (bk_st)
    );

    assign m_tdata = {1'b0, result.drawn, result.prio, result.palette,
                      result.color, result.column};
    assign m_tuser = result.from_window;

`ifndef NO_ASSERTIONS
    // a new result only appears after the sequencer loaded one
    a_rose_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(bk_st.emit))
        else $error("result valid rose without a load from the sequencer");

    // the result register is never overwritten while a result is stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_st.emit |-> !(m_tvalid && !m_tready))
        else $error("result register loaded while the sink stalls");

    // queue fill level stays within its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_st.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue count beyond depth");
`endif

endmodule

/* tb/tb_tile_map_pixel_fetch_core.sv */
// testbench for the tile map pixel fetch core: random streams checked by a scoreboard
`timescale 1ns / 1ps
module tb_tile_map_pixel_fetch_core;
    import tmpf_pkg::*;

    localparam int SCREEN_W    = 160;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 115;
    localparam int LONG_HOLD   = 300;

    localparam logic [ADDR_W-1:0]     MAP0_BASE    = 13'h1800;
    localparam logic [ADDR_W-1:0]     MAP1_BASE    = 13'h1C00;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {LAYER_NONE, LAYER_BG, LAYER_WIN} layer_t;

    class fetch_scoreboard;
        bit [7:0] vram [2][BANK_BYTES];
        bit       written [2][BANK_BYTES];
        cfg_t     regs;
        result_t  owed_pixels [$];
        int       failures;

        function new();
            regs = '0;
            regs.tile_data_select  = 1'b1;
            regs.background_enable = 1'b1;
            failures = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic v);
            case (idx)
                CFG_TILE_DATA_SEL: regs.tile_data_select      = v;
                CFG_BG_ENABLE:     regs.background_enable     = v;
                CFG_WIN_ENABLE:    regs.window_enable         = v;
                CFG_COLOR_MODE:    regs.color_mode            = v;
                CFG_BG_MAP_SEL:    regs.background_map_select = v;
                CFG_WIN_MAP_SEL:   regs.window_map_select     = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        function layer_t pick_layer(input logic [7:0] x, ly, scx, scy, wx, wy,
                                    output logic [7:0] mx, my, output logic msel);
            mx = '0;
            my = '0;
            msel = 1'b0;
            if (int'(x) >= SCREEN_W) return LAYER_NONE;
            if (regs.window_enable && wy <= ly && int'(x) + 7 >= int'(wx)) begin
                mx = x + WIN_X_OFFSET - wx;
                my = ly - wy;
                msel = regs.window_map_select;
                return LAYER_WIN;
            end
            if (regs.background_enable || regs.color_mode) begin
                mx = scx + x;
                my = scy + ly;
                msel = regs.background_map_select;
                return LAYER_BG;
            end
            return LAYER_NONE;
        endfunction

        function logic [ADDR_W-1:0] map_offset(logic msel, logic [7:0] mx, logic [7:0] my);
            return (msel ? MAP1_BASE : MAP0_BASE) + {3'b000, my[7:3], mx[7:3]};
        endfunction

        // low plane byte of the tile row under (mx, my); the high plane follows it
        function void plane_addr(input logic msel, input logic [7:0] mx, my,
                                 output logic bank, output logic [ADDR_W-1:0] addr,
                                 output logic [7:0] attr);
            logic [ADDR_W-1:0] off;
            logic [7:0]        tile;
            logic [2:0]        fy;
            off = map_offset(msel, mx, my);
            tile = vram[0][off];
            attr = regs.color_mode ? vram[1][off] : 8'h00;
            bank = regs.color_mode ? attr[ATTR_BANK_BIT] : 1'b0;
            fy = my[2:0];
            if (regs.color_mode && attr[ATTR_YFLIP_BIT]) fy = 3'd7 - fy;
            if (regs.tile_data_select)
                addr = {1'b0, tile, 4'b0000} + {9'd0, fy, 1'b0};
            else
                addr = SIGNED_TILE_BASE + {1'b0, tile ^ SIGNED_TILE_BIAS, 4'b0000}
                       + {9'd0, fy, 1'b0};
        endfunction

        function void note_transfer(logic cmd, logic [IN_TDATA_W-1:0] d);
            logic [7:0]        mx, my, attr, lo, hi;
            logic              msel, bank;
            logic [ADDR_W-1:0] addr;
            logic [2:0]        sh;
            layer_t            lyr;
            result_t           r;
            if (cmd == CMD_WRITE) begin
                vram[d[0]][d[13:1]] = d[21:14];
                written[d[0]][d[13:1]] = 1'b1;
                return;
            end
            r = '0;
            r.column = d[29:22];
            lyr = pick_layer(d[29:22], d[37:30], d[45:38], d[53:46], d[61:54], d[69:62],
                             mx, my, msel);
            if (lyr != LAYER_NONE) begin
                plane_addr(msel, mx, my, bank, addr, attr);
                lo = vram[bank][addr];
                hi = vram[bank][addr + 1'b1];
                sh = (regs.color_mode && attr[ATTR_XFLIP_BIT]) ? mx[2:0] : 3'd7 - mx[2:0];
                r.color       = {hi[sh], lo[sh]};
                // attr reads as zero in monochrome, so palette and priority drop out
                r.palette     = attr[2:0];
                r.prio        = attr[ATTR_PRIO_BIT];
                r.from_window = (lyr == LAYER_WIN);
                r.drawn       = 1'b1;
            end
            owed_pixels.push_back(r);
        endfunction

        task report(string what);
            failures++;
            if (failures <= 40) $display("%0t: %s", $time, what);
        endtask

        task check_pixel(logic [OUT_TDATA_W-1:0] d, logic win);
            result_t e;
            if (owed_pixels.size() == 0) begin
                report($sformatf("result for column %0d with no pixel owed", d[7:0]));
                return;
            end
            e = owed_pixels.pop_front();
            if (d[7:0] != e.column)
                report($sformatf("column %0d, want %0d", d[7:0], e.column));
            if (d[9:8] != e.color)
                report($sformatf("column %0d: colour %0d, want %0d", e.column, d[9:8], e.color));
            if (d[12:10] != e.palette)
                report($sformatf("column %0d: palette %0d, want %0d", e.column, d[12:10],
                                 e.palette));
            if (d[13] != e.prio)
                report($sformatf("column %0d: priority %0d, want %0d", e.column, d[13], e.prio));
            if (win != e.from_window)
                report($sformatf("column %0d: window %0d, want %0d", e.column, win,
                                 e.from_window));
            if (d[14] != e.drawn)
                report($sformatf("column %0d: drawn %0d, want %0d", e.column, d[14], e.drawn));
        endtask
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic [0:0]              s_tuser;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [0:0]              m_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [0:0]              cfg_wdata;

    fetch_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int items_sent;

    tile_map_pixel_fetch_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_item(
        input logic bank, input logic [ADDR_W-1:0] addr,
        input logic [7:0] wbyte, x, ly, scx, scy, wx, wy);
        return {2'b00, wy, wx, scy, scx, ly, x, wbyte, addr, bank};
    endfunction

    task automatic push_item(logic cmd, logic [IN_TDATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_transfer(cmd, d);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic put_byte(logic bank, logic [ADDR_W-1:0] addr, logic [7:0] v);
        push_item(CMD_WRITE, pack_item(bank, addr, v, 8'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom), 8'($urandom),
                                       8'($urandom)));
    endtask

    // writes whatever the fetch will read and has not been written yet, and a forced attribute byte, then the pixel
    task automatic fetch_pixel(input logic [7:0] x, ly, scx, scy, wx, wy,
                               input int attr_force);
        logic [7:0]        mx, my, attr;
        logic              msel, bank;
        logic [ADDR_W-1:0] off, addr;
        if (sb.pick_layer(x, ly, scx, scy, wx, wy, mx, my, msel) != LAYER_NONE) begin
            off = sb.map_offset(msel, mx, my);
            if (!sb.written[0][off]) put_byte(1'b0, off, 8'($urandom));
            if (sb.regs.color_mode && (attr_force >= 0 || !sb.written[1][off]))
                put_byte(1'b1, off, attr_force >= 0 ? 8'(attr_force) : 8'($urandom));
            sb.plane_addr(msel, mx, my, bank, addr, attr);
            if (!sb.written[bank][addr]) put_byte(bank, addr, 8'($urandom));
            if (!sb.written[bank][addr + 1'b1]) put_byte(bank, addr + 1'b1, 8'($urandom));
        end
        push_item(CMD_PIXEL, pack_item(1'($urandom), 13'($urandom), 8'($urandom),
                                       x, ly, scx, scy, wx, wy));
    endtask

    task automatic random_pixel();
        logic [7:0] x, ly, wx, wy;
        x  = ($urandom_range(9) == 0) ? 8'($urandom_range(255, SCREEN_W))
                                      : 8'($urandom_range(SCREEN_W - 1));
        ly = 8'($urandom);
        // keep the window in reach most of the time
        wy = ($urandom_range(3) != 0) ? 8'($urandom_range(ly)) : 8'($urandom);
        wx = ($urandom_range(3) != 0) ? 8'($urandom_range(SCREEN_W + 6)) : 8'($urandom);
        fetch_pixel(x, ly, 8'($urandom), 8'($urandom), wx, wy, -1);
    endtask

    task automatic settle(int tail);
        int waited;
        waited = 0;
        s_tvalid = 1'b0;
        while (sb.pending() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        // queued byte writes may still be in flight after the last pixel
        repeat (tail) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic put_reg(logic [CFG_ADDR_W-1:0] idx, logic v);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = v;
        @(posedge aclk);
        sb.set_reg(idx, v);
        @(negedge aclk);
    endtask

    task automatic apply_cfg(cfg_t c);
        put_reg(CFG_TILE_DATA_SEL, c.tile_data_select);
        put_reg(CFG_BG_ENABLE, c.background_enable);
        put_reg(CFG_WIN_ENABLE, c.window_enable);
        put_reg(CFG_COLOR_MODE, c.color_mode);
        put_reg(CFG_BG_MAP_SEL, c.background_map_select);
        put_reg(CFG_WIN_MAP_SEL, c.window_map_select);
        cfg_we = 1'b0;
    endtask

    initial begin
        cfg_t next_cfg;
        int   phase;
        int   phase_start;
        sb = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        items_sent     = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: monochrome background, unsigned tiles
        put_byte(1'b0, '0, 8'h00);
        put_byte(1'b1, '1, 8'hFF);
        fetch_pixel(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, -1);
        fetch_pixel(8'd159, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, -1);
        fetch_pixel(8'd160, 8'd10, 8'd3, 8'd4, 8'd0, 8'd0, -1);
        settle(40);

        // colour mode with window, signed tiles and upper maps
        next_cfg = '0;
        next_cfg.window_enable         = 1'b1;
        next_cfg.color_mode            = 1'b1;
        next_cfg.background_map_select = 1'b1;
        next_cfg.window_map_select     = 1'b1;
        put_reg(CFG_SPARE_LO, 1'b1);
        put_reg(CFG_SPARE_HI, 1'b1);
        apply_cfg(next_cfg);
        fetch_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF);
        fetch_pixel(8'd0, 8'd5, 8'd0, 8'd0, 8'd7, 8'd5, 8'h20);
        fetch_pixel(8'd3, 8'd100, 8'd0, 8'd0, 8'd10, 8'd90, 8'h40);
        fetch_pixel(8'd159, 8'd0, 8'd200, 8'd77, 8'd255, 8'd0, 8'h08);
        fetch_pixel(8'd20, 8'd4, 8'd255, 8'd1, 8'd0, 8'd5, 8'h87);
        fetch_pixel(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, -1);

        for (phase = 0; phase < PHASES; phase++) begin
            settle(40);
            if (phase == 0)
                next_cfg = '0;
            else if (phase == 1)
                next_cfg = '1;
            else
                next_cfg = cfg_t'($urandom);
            apply_cfg(next_cfg);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (phase == 4 || phase == 8) hold_req++;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 15)
                    put_byte(1'($urandom), 13'($urandom), 8'($urandom));
                else
                    random_pixel();
            end
        end

        settle(60);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d pixel results never arrived", sb.pending()));
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // result side ready, with a long hold-off whenever hold_req moves
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tuser[0]);
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
